// File: rtl/core/rsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types, constants and the gain table for the rhythm sample mixer.
// ----------------------------------------------------------------------------
package rsm_pkg;

	localparam int NUM_CH       = 6;
	localparam int SAMPLE_DEPTH = 16384;
	localparam int CH_W         = $clog2(NUM_CH);
	localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
	localparam int MEM_DEPTH    = NUM_CH * SAMPLE_DEPTH;
	localparam int MEM_AW       = $clog2(MEM_DEPTH);
	localparam int FRAC_W       = 10;
	localparam int POS_W        = SAMPLE_AW + FRAC_W + 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int Q_AW         = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_REG    = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;
	localparam logic [1:0] OP_SETUP  = 2'd3;

	localparam logic [7:0] ADDR_KEY    = 8'h10;
	localparam logic [7:0] ADDR_TL     = 8'h11;
	localparam logic [7:0] ADDR_PAN_LO = 8'h18;
	localparam logic [7:0] ADDR_PAN_HI = 8'h1d;

	typedef enum logic [2:0] {
		CMD_KEY_ON,
		CMD_KEY_OFF,
		CMD_TL,
		CMD_PAN,
		CMD_SAMPLE,
		CMD_SETUP,
		CMD_TICK
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [7:0]         reg_addr;
		logic [7:0]         reg_data;
		logic [2:0]         channel;
		logic [13:0]        sample_index;
		logic signed [15:0] sample_value;
		logic [14:0]        channel_length;
		logic [15:0]        channel_step;
		logic signed [31:0] left_in;
		logic signed [31:0] right_in;
	} in_t;

	typedef struct packed {
		logic signed [31:0] left_out;
		logic signed [31:0] right_out;
	} out_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CH_W-1:0]   chan;
		logic [7:0]        data;
		logic [MEM_AW-1:0] mem_addr;
		logic [15:0]       value;
		logic [POS_W-1:0]  len_fixed;
		logic [31:0]       left;
		logic [31:0]       right;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [11:0] gain_lookup(input logic [6:0] db);
		logic [16:0] base;
		logic [16:0] shifted;
		case (db[2:0])
			3'd0: base = 17'd65536;
			3'd1: base = 17'd60096;
			3'd2: base = 17'd55108;
			3'd3: base = 17'd50535;
			3'd4: base = 17'd46340;
			3'd5: base = 17'd42494;
			3'd6: base = 17'd38967;
			default: base = 17'd35733;
		endcase
		shifted = base >> db[6:3];
		return 12'((shifted - 17'd1) >> 4);
	endfunction

endpackage

// File: rtl/core/rsm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_front
// Decodes input transactions into internal commands and drops the ones
// that have no effect.
// ----------------------------------------------------------------------------
module rsm_front (
	input  rsm_pkg::in_t  in_data,
	input  logic          in_fire,
	output logic          push,
	output rsm_pkg::cmd_t push_cmd
);

	logic [31:0] len_sat;

	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		push_cmd.kind = rsm_pkg::CMD_TICK;
		len_sat  = 32'(in_data.channel_length);
		if (len_sat > 32'(rsm_pkg::SAMPLE_DEPTH)) begin
			len_sat = 32'(rsm_pkg::SAMPLE_DEPTH);
		end
		unique case (in_data.opcode)
			rsm_pkg::OP_REG: begin
				push_cmd.data = in_data.reg_data;
				if (in_data.reg_addr == rsm_pkg::ADDR_KEY) begin
					push = in_fire;
					push_cmd.kind = in_data.reg_data[7] ? rsm_pkg::CMD_KEY_OFF
						: rsm_pkg::CMD_KEY_ON;
				end else if (in_data.reg_addr == rsm_pkg::ADDR_TL) begin
					push = in_fire;
					push_cmd.kind = rsm_pkg::CMD_TL;
				end else if (in_data.reg_addr >= rsm_pkg::ADDR_PAN_LO &&
					in_data.reg_addr <= rsm_pkg::ADDR_PAN_HI &&
					32'(in_data.reg_addr[2:0]) < 32'(rsm_pkg::NUM_CH)) begin
					push = in_fire;
					push_cmd.kind = rsm_pkg::CMD_PAN;
					push_cmd.chan = rsm_pkg::CH_W'(in_data.reg_addr[2:0]);
				end
			end
			rsm_pkg::OP_SAMPLE: begin
				push_cmd.kind = rsm_pkg::CMD_SAMPLE;
				push_cmd.value = in_data.sample_value;
				push_cmd.mem_addr = rsm_pkg::MEM_AW'(32'(in_data.channel) *
					32'(rsm_pkg::SAMPLE_DEPTH)) + rsm_pkg::MEM_AW'(in_data.sample_index);
				if (32'(in_data.channel) < 32'(rsm_pkg::NUM_CH) &&
					32'(in_data.sample_index) < 32'(rsm_pkg::SAMPLE_DEPTH)) begin
					push = in_fire;
				end
			end
			rsm_pkg::OP_SETUP: begin
				push_cmd.kind = rsm_pkg::CMD_SETUP;
				push_cmd.chan = rsm_pkg::CH_W'(in_data.channel);
				push_cmd.value = in_data.channel_step;
				push_cmd.len_fixed = rsm_pkg::POS_W'(len_sat << rsm_pkg::FRAC_W);
				if (32'(in_data.channel) < 32'(rsm_pkg::NUM_CH)) begin
					push = in_fire;
				end
			end
			default: begin
				push = in_fire;
				push_cmd.kind = rsm_pkg::CMD_TICK;
				push_cmd.left = in_data.left_in;
				push_cmd.right = in_data.right_in;
			end
		endcase
	end

endmodule

// File: rtl/core/rsm_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_cmd_fifo
// Short command queue between the decoder and the execution engine.
// ----------------------------------------------------------------------------
module rsm_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rsm_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output rsm_pkg::cmd_t      pop_cmd,
	output rsm_pkg::q_status_t status
);

	rsm_pkg::cmd_t               entry_q [rsm_pkg::QUEUE_DEPTH];
	logic [rsm_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [rsm_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [rsm_pkg::Q_AW:0]      count_q;
	logic                        do_push;
	logic                        do_pop;

	assign status.full  = (count_q == (rsm_pkg::Q_AW + 1)'(rsm_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_cmd      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/rsm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_back
// Executes queued commands: channel registers, sample memory, and the
// per-tick channel walk through a read, multiply and accumulate pipeline.
// ----------------------------------------------------------------------------
module rsm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_data,
	input  rsm_pkg::cmd_t      cmd,
	input  rsm_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output rsm_pkg::out_t      out_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                           state_q;
	logic                             sat_q;
	logic [rsm_pkg::NUM_CH-1:0]       key_q;
	logic [5:0]                       tl_q;
	logic [1:0]                       pan_q  [rsm_pkg::NUM_CH];
	logic [4:0]                       lvl_q  [rsm_pkg::NUM_CH];
	logic [rsm_pkg::POS_W-1:0]        pos_q  [rsm_pkg::NUM_CH];
	logic [rsm_pkg::POS_W-1:0]        len_q  [rsm_pkg::NUM_CH];
	logic [15:0]                      step_q [rsm_pkg::NUM_CH];
	logic [rsm_pkg::CH_W-1:0]         ch_q;
	logic [31:0]                      acc_l_q;
	logic [31:0]                      acc_r_q;

	logic [15:0]                      mem [rsm_pkg::MEM_DEPTH];
	logic [15:0]                      rd_data_q;
	logic                             mem_we;
	logic [rsm_pkg::MEM_AW-1:0]       rd_addr;

	logic                             act_s1;
	logic [1:0]                       pan_s1;
	logic [11:0]                      vol_s1;
	logic                             act_s2;
	logic [1:0]                       pan_s2;
	logic signed [28:0]               prod_s2;

	logic                             ch_active;
	logic [rsm_pkg::NUM_CH-1:0]       key_on_bits;
	logic [6:0]                       db;
	logic signed [15:0]               smp;
	logic signed [12:0]               vol_ext;
	logic signed [16:0]               scaled;
	logic                             tick_start;
	logic                             out_load;

	function automatic logic [31:0] mix_add(input logic [31:0] acc,
		input logic signed [16:0] addv, input logic sat);
		logic signed [32:0] sum;
		sum = $signed({acc[31], acc}) + 33'(addv);
		if (sat) begin
			if (sum > 33'sd32767) begin
				sum = 33'sd32767;
			end else if (sum < -33'sd32768) begin
				sum = -33'sd32768;
			end
		end
		return sum[31:0];
	endfunction

	assign pop         = (state_q == ST_IDLE) && !q_status.empty;
	assign tick_start  = pop && (cmd.kind == rsm_pkg::CMD_TICK);
	assign mem_we      = pop && (cmd.kind == rsm_pkg::CMD_SAMPLE);
	assign key_on_bits = cmd.data[rsm_pkg::NUM_CH-1:0];
	assign ch_active   = (state_q == ST_RUN) && key_q[ch_q] && (pos_q[ch_q] < len_q[ch_q]);
	assign rd_addr     = rsm_pkg::MEM_AW'(32'(ch_q) * 32'(rsm_pkg::SAMPLE_DEPTH)) +
		rsm_pkg::MEM_AW'(pos_q[ch_q][rsm_pkg::FRAC_W +: rsm_pkg::SAMPLE_AW]);
	assign db          = 7'(tl_q) + 7'(lvl_q[ch_q]);
	assign smp         = $signed(rd_data_q);
	assign vol_ext     = $signed({1'b0, vol_s1});
	assign scaled      = prod_s2[28:12];
	assign out_load    = (state_q == ST_DONE) && !act_s1 && !act_s2 &&
		(!out_valid || out_ready);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cmd.mem_addr] <= cmd.value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		pan_s1  <= pan_q[ch_q];
		vol_s1  <= rsm_pkg::gain_lookup(db);
		pan_s2  <= pan_s1;
		prod_s2 <= smp * vol_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sat_q     <= 1'b0;
			key_q     <= '0;
			tl_q      <= '0;
			ch_q      <= '0;
			act_s1    <= 1'b0;
			act_s2    <= 1'b0;
			out_valid <= 1'b0;
			acc_l_q   <= '0;
			acc_r_q   <= '0;
			out_data  <= '0;
			for (int i = 0; i < rsm_pkg::NUM_CH; i++) begin
				pan_q[i]  <= '0;
				lvl_q[i]  <= '0;
				pos_q[i]  <= '1;
				len_q[i]  <= '0;
				step_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				sat_q <= cfg_data;
			end
			act_s1 <= ch_active;
			act_s2 <= act_s1;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (act_s2) begin
				acc_l_q <= mix_add(acc_l_q, pan_s2[1] ? scaled : 17'sd0, sat_q);
				acc_r_q <= mix_add(acc_r_q, pan_s2[0] ? scaled : 17'sd0, sat_q);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (cmd.kind)
							rsm_pkg::CMD_KEY_ON: begin
								key_q <= key_q | key_on_bits;
								for (int i = 0; i < rsm_pkg::NUM_CH; i++) begin
									if (key_on_bits[i]) begin
										pos_q[i] <= '0;
									end
								end
							end
							rsm_pkg::CMD_KEY_OFF: begin
								key_q <= key_q & ~key_on_bits;
							end
							rsm_pkg::CMD_TL: begin
								tl_q <= ~cmd.data[5:0];
							end
							rsm_pkg::CMD_PAN: begin
								pan_q[cmd.chan] <= cmd.data[7:6];
								lvl_q[cmd.chan] <= ~cmd.data[4:0];
							end
							rsm_pkg::CMD_SETUP: begin
								len_q[cmd.chan]  <= cmd.len_fixed;
								step_q[cmd.chan] <= cmd.value;
							end
							default: begin
							end
						endcase
					end
					if (tick_start) begin
						acc_l_q <= cmd.left;
						acc_r_q <= cmd.right;
						ch_q    <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (ch_active) begin
						pos_q[ch_q] <= pos_q[ch_q] + rsm_pkg::POS_W'(step_q[ch_q]);
					end
					if (ch_q == rsm_pkg::CH_W'(rsm_pkg::NUM_CH - 1)) begin
						state_q <= ST_DONE;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_data.left_out  <= acc_l_q;
						out_data.right_out <= acc_r_q;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/rhythm_sample_mixer.sv
`timescale 1ns / 1ps
// A tick transaction's result is loaded once its channel walk ends and the pipe drains;
// the drain holds the result only when either of the last two channels is playing.
// Ticks are mixed one at a time, bounded by the six channel reads through the
// single sample memory port and the three-stage read, multiply, accumulate pipe.
// Register, sample and setup transactions run one per cycle from a 4-entry queue when idle.
// Reset clears channel/mixer registers (positions all ones), idles channels, keeps samples.
// ----------------------------------------------------------------------------
// rhythm_sample_mixer
// Six-channel drum sample player that adds its voices onto a stereo mix.
// ----------------------------------------------------------------------------
module rhythm_sample_mixer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  rsm_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rsm_pkg::out_t out_data
);

	logic               push;
	rsm_pkg::cmd_t      push_cmd;
	logic               pop;
	rsm_pkg::cmd_t      pop_cmd;
	rsm_pkg::q_status_t q_status;

	assign in_ready = !q_status.full;

	rsm_front u_front (
		.in_data  (in_data),
		.in_fire  (in_valid && in_ready),
		.push     (push),
		.push_cmd (push_cmd)
	);

	rsm_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.status   (q_status)
	);

	rsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (pop_cmd),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
